// ----- src/kptl_pkg.sv -----
// -----------------------------------------------------------------------------
// kptl_pkg: shared types and constants
// Request codes, result codes, parser phases, controller states and the
// command/status structs between controller and datapath.
// -----------------------------------------------------------------------------
package kptl_pkg;

   localparam int unsigned MaxPairsDefault = 256;
   localparam int unsigned LenW            = 20;
   localparam int unsigned GlyphW          = 16;

   // request kinds
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_DONE   = 3'd1;
   localparam logic [2:0] ST_BAD    = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_LOOKUP = 3'd4;

   // table layout
   localparam logic [7:0] TBL_HDR_BYTES = 8'd4;
   localparam logic [7:0] SUB_HDR_BYTES = 8'd6;
   localparam logic [7:0] F0_HDR_BYTES  = 8'd8;
   localparam logic [7:0] PAIR_BYTES    = 8'd6;
   localparam logic [7:0] NPAIRS_BYTES  = 8'd2;
   localparam logic [7:0] F0_MIN_LEN    = 8'd14;
   localparam logic [7:0] PAIR_OFFSET   = 8'd14;

   typedef enum logic [2:0] {
      PH_TABLE,
      PH_SUB,
      PH_F0,
      PH_PAIRS,
      PH_SKIP,
      PH_TAIL,
      PH_STOP
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic accept;    // take a request this cycle
      logic exec;      // run the latched request
      logic scan_run;  // step the store scan
      logic out_valid; // result register holds a result
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_lookup; // latched request is a lookup
      logic scan_done; // scan has its answer this cycle
   } dp_status_type;

endpackage

// ----- src/kptl_ctrl.sv -----
// -----------------------------------------------------------------------------
// kptl_ctrl: request sequencer
// Accepts one request, runs it in the datapath, holds the result until taken.
// -----------------------------------------------------------------------------
module kptl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   input  kptl_pkg::dp_status_type sts,
   output kptl_pkg::ctrl_cmd_type  cmd
);
   import kptl_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = sts.is_lookup ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            if (sts.scan_done) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:  cmd.accept    = 1'b1;
         S_EXEC:  cmd.exec      = 1'b1;
         S_SCAN:  cmd.scan_run  = 1'b1;
         S_RESP:  cmd.out_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- src/kptl_dp.sv -----
// -----------------------------------------------------------------------------
// kptl_dp: parser, pair store and lookup scan
// One table byte is parsed per exec step; lookups scan the pair store one
// entry per cycle through a registered read port.
// -----------------------------------------------------------------------------
module kptl_dp #(
   parameter int unsigned MAX_PAIRS = kptl_pkg::MaxPairsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kptl_pkg::ctrl_cmd_type     cmd,
   output kptl_pkg::dp_status_type    sts,
   input  logic [1:0]                 req_cmd,
   input  logic [7:0]                 req_byte,
   input  logic [kptl_pkg::GlyphW-1:0] req_left,
   input  logic [kptl_pkg::GlyphW-1:0] req_right,
   input  logic                       csr_we,
   input  logic [kptl_pkg::LenW-1:0]  csr_wdata,
   output logic [2:0]                 res_status,
   output logic                       res_found,
   output logic [15:0]                res_adjust
);
   import kptl_pkg::*;

   localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
   localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_PAIRS);

   // latched request
   logic [1:0]        cmd_ff;
   logic [7:0]        byte_ff;
   logic [15:0]       left_ff, right_ff;
   logic [LenW-1:0]   tlen_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_cmd;
         byte_ff  <= req_byte;
         left_ff  <= req_left;
         right_ff <= req_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff <= '0;
      end else if (csr_we) begin
         tlen_ff <= csr_wdata;
      end
   end

   // parser state
   phase_type       phase_ff, phase_in;
   logic [LenW-1:0] pos_ff, pos_in;
   logic [15:0]     subs_ff, subs_in;
   logic [LenW-1:0] send_ff, send_in;
   logic [15:0]     pairs_ff, pairs_in;
   logic [47:0]     asm_ff, asm_in;
   logic [3:0]      fb_ff, fb_in;
   logic [2:0]      fault_ff, fault_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [2:0]      pstat;
   logic            we;

   logic [LenW:0]   sub_start, sub_lim;
   logic [15:0]     f_ver, f_len, f_cov, f_n;
   logic [LenW+2:0] f0_lim;
   logic            halt;
   logic [2:0]      halt_code;
   logic [15:0]     subs_dec;

   assign f_ver = asm_in[47:32];
   assign f_len = asm_in[31:16];
   assign f_cov = asm_in[15:0];
   assign f_n   = asm_in[15:0];
   assign sub_start = {1'b0, pos_ff - LenW'(5)};
   assign sub_lim   = sub_start + {{(LenW-15){1'b0}}, f_len};
   // start + 14 + 6n, start = pos - 7
   assign f0_lim = {3'b0, pos_ff} - (LenW+3)'(7) + (LenW+3)'(PAIR_OFFSET)
                 + {{(LenW-15){1'b0}}, f_n, 2'b0} + {{(LenW-14){1'b0}}, f_n, 1'b0};
   // subtable count is set in the table header and decremented at each subtable boundary
   assign subs_dec = subs_ff - 16'd1;

   // one parse step
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      subs_in   = subs_ff;
      send_in   = send_ff;
      pairs_in  = pairs_ff;
      asm_in    = asm_ff;
      fb_in     = fb_ff;
      fault_in  = fault_ff;
      count_in  = count_ff;
      pstat     = ST_OK;
      we        = 1'b0;
      halt      = 1'b0;
      halt_code = ST_BAD;
      if (phase_ff == PH_STOP) begin
         pstat = fault_ff;
      end else if (pos_ff >= tlen_ff) begin
         halt = 1'b1;
      end else begin
         asm_in = {asm_ff[39:0], byte_ff};
         fb_in  = fb_ff + 4'd1;
         unique case (phase_ff)
            PH_TABLE: begin
               if (fb_in == 4'(TBL_HDR_BYTES)) begin
                  subs_in  = asm_in[15:0];
                  fb_in    = '0;
                  phase_in = (asm_in[15:0] != 16'd0) ? PH_SUB : PH_TAIL;
               end
            end
            PH_SUB: begin
               if (fb_in == 4'(SUB_HDR_BYTES)) begin
                  if (f_len < 16'(SUB_HDR_BYTES) || sub_lim > {1'b0, tlen_ff}) begin
                     halt = 1'b1;
                  end else begin
                     send_in  = sub_lim[LenW-1:0];
                     fb_in    = '0;
                     phase_in = (f_ver != 16'd0 || f_cov[15:8] != 8'd0 ||
                                 f_len < 16'(F0_MIN_LEN)) ? PH_SKIP : PH_F0;
                  end
               end
            end
            PH_F0: begin
               if (fb_in == 4'(NPAIRS_BYTES)) begin
                  if (f0_lim > {3'b0, send_ff}) halt = 1'b1;
                  else pairs_in = f_n;
               end
               if (fb_in == 4'(F0_HDR_BYTES)) begin
                  fb_in    = '0;
                  phase_in = (pairs_ff != 16'd0) ? PH_PAIRS : PH_SKIP;
               end
            end
            PH_PAIRS: begin
               if (fb_in == 4'(PAIR_BYTES)) begin
                  fb_in = '0;
                  if (count_ff >= MaxCnt) begin
                     halt      = 1'b1;
                     halt_code = ST_FULL;
                  end else begin
                     we       = 1'b1;
                     count_in = count_ff + CW'(1);
                     pairs_in = pairs_ff - 16'd1;
                     if (pairs_in == 16'd0) phase_in = PH_SKIP;
                  end
               end
            end
            default: fb_in = '0;
         endcase
         if (!halt) begin
            pos_in = pos_ff + LenW'(1);
            if ((phase_in == PH_F0 || phase_in == PH_PAIRS || phase_in == PH_SKIP) &&
                pos_in == send_in) begin
               subs_in  = subs_dec;
               fb_in    = '0;
               phase_in = (subs_dec != 16'd0) ? PH_SUB : PH_TAIL;
            end
            if (pos_in == tlen_ff) begin
               halt      = 1'b1;
               halt_code = (phase_in == PH_TAIL) ? ST_DONE : ST_BAD;
            end
         end
      end
      if (halt) begin
         phase_in = PH_STOP;
         fault_in = halt_code;
         pstat    = halt_code;
      end
   end

   logic do_load, do_clear, do_lookup;
   assign do_load   = cmd.exec && (cmd_ff == CMD_LOAD);
   assign do_clear  = cmd.exec && (cmd_ff == CMD_CLEAR);
   assign do_lookup = cmd.exec && (cmd_ff == CMD_LOOKUP);

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         phase_ff <= PH_TABLE;
         pos_ff   <= '0;
         subs_ff  <= '0;
         send_ff  <= '0;
         pairs_ff <= '0;
         asm_ff   <= '0;
         fb_ff    <= '0;
         fault_ff <= ST_OK;
         count_ff <= '0;
      end else if (do_load) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         subs_ff  <= subs_in;
         send_ff  <= send_in;
         pairs_ff <= pairs_in;
         asm_ff   <= asm_in;
         fb_ff    <= fb_in;
         fault_ff <= fault_in;
         count_ff <= count_in;
      end
   end

   // pair store: {left, right, adjust}
   logic [47:0]   mem [MAX_PAIRS];
   logic [47:0]   rd_ff;
   logic [CW-1:0] issue_ff;
   logic          pend_ff;
   logic          issue_ok, match;

   assign issue_ok = issue_ff < count_ff;
   assign match    = pend_ff && rd_ff[47:32] == left_ff && rd_ff[31:16] == right_ff;

   always_ff @(posedge clock) begin
      if (do_load && we) mem[count_ff[AW-1:0]] <= asm_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_run && issue_ok) rd_ff <= mem[issue_ff[AW-1:0]];
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset || do_lookup) begin
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (cmd.scan_run) begin
         pend_ff <= issue_ok;
         if (issue_ok) issue_ff <= issue_ff + CW'(1);
      end
   end

   // done on a hit, or once the last stored entry has been compared
   assign sts.is_lookup = (cmd_ff == CMD_LOOKUP);
   assign sts.scan_done = cmd.scan_run && (match || !issue_ok);

   // result register
   logic [2:0]  rstat_ff;
   logic        rfound_ff;
   logic [15:0] radj_ff;

   always_ff @(posedge clock) begin
      if (do_load) begin
         rstat_ff  <= pstat;
         rfound_ff <= 1'b0;
         radj_ff   <= '0;
      end else if (cmd.exec && !do_lookup) begin
         rstat_ff  <= ST_OK;
         rfound_ff <= 1'b0;
         radj_ff   <= '0;
      end else if (sts.scan_done) begin
         rstat_ff  <= ST_LOOKUP;
         rfound_ff <= match;
         radj_ff   <= match ? rd_ff[15:0] : 16'd0;
      end
   end

   assign res_status = rstat_ff;
   assign res_found  = rfound_ff;
   assign res_adjust = radj_ff;

endmodule

// ----- src/kern_pair_table_parse_lookup.sv -----
// -----------------------------------------------------------------------------
// kern_pair_table_parse_lookup: kerning table parser and pair lookup
// Byte load, clear and unused requests pass through an exec state to the result;
// a lookup adds a scan state that reads the stored pairs, one store read per cycle,
// until a hit or the last stored pair. One request is in flight at a time; the next
// is accepted once the result is taken. Reset (synchronous) empties the store and
// restarts the parse; table_length resets to 0.
// -----------------------------------------------------------------------------
module kern_pair_table_parse_lookup #(
   parameter int unsigned MAX_PAIRS = kptl_pkg::MaxPairsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], left_glyph[23:8], right_glyph[39:24]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], found[3], adjust[19:4], zero[23:20]
   input  logic        csr_we,
   input  logic [19:0] csr_wdata    // table_length
);
   import kptl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic [2:0]    res_status;
   logic          res_found;
   logic [15:0]   res_adjust;

   kptl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kptl_dp #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_cmd    (req_tuser),
      .req_byte   (req_tdata[7:0]),
      .req_left   (req_tdata[23:8]),
      .req_right  (req_tdata[39:24]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .res_status (res_status),
      .res_found  (res_found),
      .res_adjust (res_adjust)
   );

   assign req_tready = cmd.accept;
   assign rsp_tvalid = cmd.out_valid;
   assign rsp_tdata  = {4'b0, res_adjust, res_found, res_status};

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accept not followed by busy");

   a_found_is_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2:0] == ST_LOOKUP)
      else $error("found set on non-lookup result");
`endif

endmodule

// ----- tb/testbench.sv -----
// -----------------------------------------------------------------------------
// testbench: kerning table parser and pair lookup regression
// Streams kerning tables byte by byte and follows each with pair lookups.
// Most tables are well formed with random content. The rest are truncated,
// corrupted or overrun. A scoreboard tracks the parser and the pair store
// and checks every result in order.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import kptl_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned STORE_DEPTH = MaxPairsDefault;
   localparam int unsigned IDLE_LIMIT = 4000;
   // random tables run up to here; the store overflow table adds ~1560 more
   localparam int unsigned ITEM_TARGET = 200;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [15:0] adjust;
   } kern_result_type;

   // scoreboard: parser and pair-store tracker plus expected results in order
   class kern_scoreboard;
      kern_result_type expected_results[$];
      int unsigned    errors;
      int unsigned    table_len;
      logic [15:0]    left_store[STORE_DEPTH];
      logic [15:0]    right_store[STORE_DEPTH];
      logic [15:0]    adjust_store[STORE_DEPTH];
      int unsigned    pair_count;
      int unsigned    byte_pos;
      phase_type      phase;
      int unsigned    subs_left;
      int unsigned    sub_end;
      int unsigned    pairs_left;
      logic [47:0]    shift_bytes;
      int unsigned    group_bytes;
      logic [2:0]     stop_code;

      function void restart();
         pair_count = 0;
         byte_pos = 0;
         phase = PH_TABLE;
         subs_left = 0;
         sub_end = 0;
         pairs_left = 0;
         shift_bytes = '0;
         group_bytes = 0;
         stop_code = ST_OK;
      endfunction

      function logic [2:0] halt(logic [2:0] code);
         phase = PH_STOP;
         stop_code = code;
         return code;
      endfunction

      function logic [2:0] parse_byte(logic [7:0] b);
         int unsigned pos, ver, len, cov, start, n;
         pos = byte_pos;
         if (phase == PH_STOP) return stop_code;
         if (pos >= table_len) return halt(ST_BAD);
         shift_bytes = {shift_bytes[39:0], b};
         group_bytes++;
         case (phase)
            PH_TABLE: begin
               if (group_bytes == 4) begin
                  subs_left = shift_bytes[15:0];
                  group_bytes = 0;
                  phase = (subs_left != 0) ? PH_SUB : PH_TAIL;
               end
            end
            PH_SUB: begin
               if (group_bytes == 6) begin
                  ver = shift_bytes[47:32];
                  len = shift_bytes[31:16];
                  cov = shift_bytes[15:0];
                  start = pos - 5;
                  if (len < 6 || start + len > table_len) return halt(ST_BAD);
                  sub_end = start + len;
                  group_bytes = 0;
                  phase = (ver != 0 || (cov >> 8) != 0 || len < 14) ? PH_SKIP : PH_F0;
               end
            end
            PH_F0: begin
               if (group_bytes == 2) begin
                  n = shift_bytes[15:0];
                  start = pos - 7;
                  if (start + 14 + 6 * n > sub_end) return halt(ST_BAD);
                  pairs_left = n;
               end
               if (group_bytes == 8) begin
                  group_bytes = 0;
                  phase = (pairs_left != 0) ? PH_PAIRS : PH_SKIP;
               end
            end
            PH_PAIRS: begin
               if (group_bytes == 6) begin
                  group_bytes = 0;
                  if (pair_count >= STORE_DEPTH) return halt(ST_FULL);
                  left_store[pair_count] = shift_bytes[47:32];
                  right_store[pair_count] = shift_bytes[31:16];
                  adjust_store[pair_count] = shift_bytes[15:0];
                  pair_count++;
                  pairs_left--;
                  if (pairs_left == 0) phase = PH_SKIP;
               end
            end
            default: group_bytes = 0;
         endcase
         byte_pos = pos + 1;
         // subtable boundary reached
         if ((phase == PH_F0 || phase == PH_PAIRS || phase == PH_SKIP) &&
             byte_pos == sub_end) begin
            subs_left = (subs_left - 1) & 16'hFFFF;
            group_bytes = 0;
            phase = (subs_left != 0) ? PH_SUB : PH_TAIL;
         end
         if (byte_pos == table_len) return halt(phase == PH_TAIL ? ST_DONE : ST_BAD);
         return ST_OK;
      endfunction

      function void note_request(logic [1:0] cmd, logic [7:0] b, logic [15:0] l,
                                 logic [15:0] r);
         kern_result_type res;
         res = '0;
         case (cmd)
            CMD_LOAD: res.status = parse_byte(b);
            CMD_LOOKUP: begin
               res.status = ST_LOOKUP;
               for (int i = 0; i < pair_count; i++) begin
                  if (left_store[i] == l && right_store[i] == r) begin
                     res.found = 1'b1;
                     res.adjust = adjust_store[i];
                     break;
                  end
               end
            end
            CMD_CLEAR: restart();
            default: ;
         endcase
         expected_results.push_back(res);
      endfunction

      function void check_result(logic [23:0] tdata);
         kern_result_type want;
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: %h", tdata);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (tdata[2:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, tdata[2:0]);
            errors++;
         end
         if (tdata[3] != want.found) begin
            $error("found: expected %0d, got %0d", want.found, tdata[3]);
            errors++;
         end
         if (tdata[19:4] != want.adjust) begin
            $error("adjust: expected %0d, got %0d", $signed(want.adjust),
                   $signed(tdata[19:4]));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // data_byte[7:0], left_glyph[23:8], right_glyph[39:24]
   logic [1:0]  req_tuser = '0;   // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // status[2:0], found[3], adjust[19:4]
   logic        csr_we = 1'b0;
   logic [19:0] csr_wdata = '0;

   kern_scoreboard sb = new();
   int unsigned    items_sent;
   int unsigned    burst_left;
   int unsigned    idle_cycles;
   int unsigned    rx_cycle;
   int unsigned    rx_mode;
   logic [7:0]     table_bytes[$];
   logic [15:0]    known_left[$];
   logic [15:0]    known_right[$];

   kern_pair_table_parse_lookup u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stall pattern, switching among four randomly chosen modes
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 300 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         2: rsp_tready <= ((rx_cycle % 11) < 4);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("kern_pair_table_parse_lookup regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic [15:0] l,
                               logic [15:0] r);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {r, l, b};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, b, l, r);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_request(CMD_LOAD, b, 16'($urandom), 16'($urandom));
   endtask

   // wait for every outstanding result, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_table_length(logic [19:0] len);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      sb.table_len = len;
      csr_we <= 1'b0;
   endtask

   function automatic void push16(logic [15:0] v);
      table_bytes.push_back(v[15:8]);
      table_bytes.push_back(v[7:0]);
   endfunction

   function automatic logic [15:0] pick_glyph();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
   endfunction

   // well-formed table: format-0, foreign and short subtables, optional tail
   // a large pair_max asks for exactly that many pairs in format-0 subtables
   function automatic void build_table(int unsigned n_sub, int unsigned pair_max);
      int unsigned kind, n, pad, len;
      logic [15:0] l, r;
      table_bytes.delete();
      push16(16'($urandom_range(0, 1)));
      push16(16'(n_sub));
      for (int s = 0; s < n_sub; s++) begin
         kind = (pair_max > 20) ? 0 : $urandom_range(0, 4);
         if (kind <= 1 || kind == 4) begin
            n = (pair_max > 20) ? pair_max : $urandom_range(0, pair_max);
            pad = (kind == 4) ? $urandom_range(1, 4) : 0;
            len = 14 + 6 * n + pad;
            push16(16'd0);
            push16(16'(len));
            push16({8'h00, 8'($urandom)});
            push16(16'(n));
            repeat (3) push16(16'($urandom));
            for (int i = 0; i < n; i++) begin
               l = pick_glyph();
               r = pick_glyph();
               known_left.push_back(l);
               known_right.push_back(r);
               push16(l);
               push16(r);
               push16(16'($urandom));
            end
            repeat (pad) table_bytes.push_back(8'($urandom));
         end else begin
            // version or format nonzero, or a format-0 length below 14
            len = (kind == 3) ? $urandom_range(6, 13) : $urandom_range(6, 20);
            push16((kind == 2 && $urandom_range(0, 1)) ? 16'($urandom_range(1, 65535)) : 16'd0);
            push16(16'(len));
            push16((kind == 2) ? {8'($urandom_range(1, 255)), 8'($urandom)} : 16'($urandom));
            repeat (len - 6) table_bytes.push_back(8'($urandom));
         end
      end
      repeat ($urandom_range(0, 2) * $urandom_range(0, 1))
         table_bytes.push_back(8'($urandom));
   endfunction

   task automatic run_lookups(int unsigned count);
      int unsigned k;
      for (int i = 0; i < count; i++) begin
         if (known_left.size() != 0 && $urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, known_left.size() - 1);
            send_request(CMD_LOOKUP, 8'($urandom), known_left[k], known_right[k]);
         end else begin
            send_request(CMD_LOOKUP, 8'($urandom), pick_glyph(), pick_glyph());
         end
      end
   endtask

   // one table pass: length register, clear, bytes (possibly broken), lookups
   task automatic run_table(int unsigned n_sub, int unsigned pair_max, bit broken);
      int unsigned len, idx, extra;
      known_left.delete();
      known_right.delete();
      build_table(n_sub, pair_max);
      len = table_bytes.size();
      extra = 0;
      if (broken) begin
         case ($urandom_range(0, 3))
            0: len = len - $urandom_range(1, (len > 4) ? 4 : len);
            1: begin
               idx = $urandom_range(0, table_bytes.size() - 1);
               table_bytes[idx] = table_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            2: extra = $urandom_range(1, 3);
            default: len = len + $urandom_range(1, 3);
         endcase
      end
      write_table_length(20'(len));
      send_request(CMD_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
      foreach (table_bytes[i]) begin
         send_byte(table_bytes[i]);
         if ($urandom_range(0, 40) == 0) run_lookups(1);
         if ($urandom_range(0, 80) == 0)
            send_request(CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
      end
      repeat (extra) send_byte(8'($urandom));
      run_lookups($urandom_range(4, 14));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, unused command, zero length
      send_request(CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000);
      send_request(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
      write_table_length(20'd0);
      send_byte(8'hFF);
      send_byte(8'h00);
      // directed: extreme glyphs and adjustments, longest table length
      write_table_length(20'hFFFFF);
      send_request(CMD_CLEAR, 8'h00, 16'h0000, 16'h0000);
      table_bytes.delete();
      push16(16'd0); push16(16'd1);
      push16(16'd0); push16(16'd26); push16(16'd0);
      push16(16'd2); repeat (3) push16(16'd0);
      push16(16'h0000); push16(16'hFFFF); push16(16'h8000);
      push16(16'hFFFF); push16(16'h0000); push16(16'h7FFF);
      foreach (table_bytes[i]) send_byte(table_bytes[i]);
      send_request(CMD_LOOKUP, 8'h00, 16'h0000, 16'hFFFF);
      send_request(CMD_LOOKUP, 8'h00, 16'hFFFF, 16'h0000);
      send_request(CMD_LOOKUP, 8'h00, 16'hFFFF, 16'hFFFF);

      // random tables, about a fifth of them broken
      while (items_sent < ITEM_TARGET)
         run_table($urandom_range(0, 3), 6, $urandom_range(0, 4) == 0);
      // one table overflowing the pair store by one pair
      run_table(1, STORE_DEPTH + 1, 1'b0);
      run_table(2, 4, 1'b0);

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_results.size() == 0)
         $display("kern_pair_table_parse_lookup regression: pass");
      else
         $display("kern_pair_table_parse_lookup regression: fail");
      $finish;
   end
endmodule

// ----- kern_pair_table_parse_lookup.f -----
src/kptl_pkg.sv
src/kptl_ctrl.sv
src/kptl_dp.sv
src/kern_pair_table_parse_lookup.sv
tb/testbench.sv
